// ----- hw/rtl/cep_pkg.sv -----
package cep_pkg;

  localparam int QUEUE_DEPTH = 4;
  localparam int QPTR_W      = 2;
  localparam int QCNT_W      = 3;

  localparam logic [1:0] PERM_FIRST  = 2'd0;
  localparam logic [1:0] PERM_SECOND = 2'd1;
  localparam logic [1:0] PERM_THIRD  = 2'd2;

  typedef struct packed {
    logic signed [31:0] a;
    logic signed [31:0] ca;
    logic signed [31:0] ba;
    logic signed [31:0] d;
    logic signed [31:0] w1;
    logic               last;
  } cep_item_t;

  typedef struct packed {
    logic full;
    logic empty;
  } cep_qstat_t;

  typedef struct packed {
    logic [1:0] perm;
    logic       refl;
    logic       run_end;
    logic       set_end;
  } cep_tag_t;

  function automatic logic signed [31:0] fx_sat(input logic signed [32:0] v);
    logic signed [31:0] res;
    priority if (v > 33'sd2147483647) begin
      res = 32'sh7fffffff;
    end else if (v < -33'sd2147483648) begin
      res = 32'sh80000000;
    end else begin
      res = v[31:0];
    end
    return res;
  endfunction

  function automatic logic signed [31:0] fx_add(input logic signed [31:0] x,
                                                input logic signed [31:0] y);
    return fx_sat({x[31], x} + {y[31], y});
  endfunction

  function automatic logic signed [31:0] fx_sub(input logic signed [31:0] x,
                                                input logic signed [31:0] y);
    return fx_sat({x[31], x} - {y[31], y});
  endfunction

  // rounded to nearest, ties up, then saturated
  function automatic logic signed [31:0] fx_mul(input logic signed [31:0] x,
                                                input logic signed [31:0] y,
                                                input int frac);
    logic signed [63:0] prod;
    logic signed [63:0] shf;
    logic signed [31:0] res;
    prod = 64'(x) * 64'(y);
    prod = prod + (64'sd1 <<< (frac - 1));
    shf  = prod >>> frac;
    priority if (shf > 64'sd2147483647) begin
      res = 32'sh7fffffff;
    end else if (shf < -64'sd2147483648) begin
      res = 32'sh80000000;
    end else begin
      res = shf[31:0];
    end
    return res;
  endfunction

endpackage

// ----- hw/rtl/cep_front.sv -----
module cep_front #(
  parameter int FRAC_BITS = 30
) (
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 in_valid,
  output logic                 in_stall,
  input  logic [30:0]          coord_a,
  input  logic [30:0]          coord_b,
  input  logic [30:0]          coord_c,
  input  logic [30:0]          coord_d,
  input  logic [30:0]          weight_in,
  input  logic                 last_point,
  input  cep_pkg::cep_qstat_t  qstat,
  output logic                 push,
  output cep_pkg::cep_item_t   push_item
);

  logic               s1_valid;
  logic signed [31:0] s1_a;
  logic signed [31:0] s1_d;
  logic signed [31:0] s1_w;
  logic signed [31:0] s1_aa;
  logic signed [31:0] s1_ca;
  logic signed [31:0] s1_ba;
  logic               s1_last;
  logic               s2_valid;
  cep_pkg::cep_item_t s2_item;
  logic               move;
  logic signed [31:0] a_ext;

  assign a_ext    = {1'b0, coord_a};
  assign move     = !s2_valid || !qstat.full;
  assign in_stall = !move;
  assign push     = s2_valid && !qstat.full;
  assign push_item = s2_item;

  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid <= 1'b0;
      s2_valid <= 1'b0;
    end else if (move) begin
      s1_valid <= in_valid;
      s2_valid <= s1_valid;
    end
  end

  // products of the base point
  always_ff @(posedge clk) begin
    if (move) begin
      s1_a    <= a_ext;
      s1_d    <= {1'b0, coord_d};
      s1_w    <= {1'b0, weight_in};
      s1_aa   <= cep_pkg::fx_mul(a_ext, a_ext, FRAC_BITS);
      s1_ca   <= cep_pkg::fx_mul({1'b0, coord_c}, a_ext, FRAC_BITS);
      s1_ba   <= cep_pkg::fx_mul({1'b0, coord_b}, a_ext, FRAC_BITS);
      s1_last <= last_point;
      s2_item.a    <= s1_a;
      s2_item.ca   <= s1_ca;
      s2_item.ba   <= s1_ba;
      s2_item.d    <= s1_d;
      s2_item.w1   <= cep_pkg::fx_mul(s1_aa, s1_w, FRAC_BITS);
      s2_item.last <= s1_last;
    end
  end

endmodule

// ----- hw/rtl/cep_queue.sv -----
module cep_queue (
  input  logic                clk,
  input  logic                rst,
  input  logic                push,
  input  cep_pkg::cep_item_t  push_item,
  input  logic                pop,
  output cep_pkg::cep_item_t  head_item,
  output cep_pkg::cep_qstat_t qstat
);

  cep_pkg::cep_item_t              mem [cep_pkg::QUEUE_DEPTH];
  logic [cep_pkg::QPTR_W-1:0]      wr_ptr;
  logic [cep_pkg::QPTR_W-1:0]      rd_ptr;
  logic [cep_pkg::QCNT_W-1:0]      count;

  assign qstat.full  = (count == cep_pkg::QCNT_W'(cep_pkg::QUEUE_DEPTH));
  assign qstat.empty = (count == '0);
  assign head_item   = mem[rd_ptr];

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (push) begin
        wr_ptr <= wr_ptr + 1'b1;
      end
      if (pop) begin
        rd_ptr <= rd_ptr + 1'b1;
      end
      unique case ({push, pop})
        2'b10:   count <= count + 1'b1;
        2'b01:   count <= count - 1'b1;
        default: count <= count;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      mem[wr_ptr] <= push_item;
    end
  end

endmodule

// ----- hw/rtl/cep_back.sv -----
module cep_back #(
  parameter int FRAC_BITS = 30
) (
  input  logic                clk,
  input  logic                rst,
  input  cep_pkg::cep_item_t  head_item,
  input  cep_pkg::cep_qstat_t qstat,
  output logic                pop,
  output logic                out_valid,
  input  logic                out_stall,
  output logic signed [31:0]  out_x0,
  output logic signed [31:0]  out_x1,
  output logic signed [31:0]  out_x2,
  output logic signed [31:0]  out_x3,
  output logic signed [31:0]  out_x4,
  output logic signed [31:0]  weight_out,
  output logic [1:0]          perm_index,
  output logic                reflected,
  output logic                last_of_run,
  output logic                end_of_set
);

  localparam logic signed [31:0] ONE =
    (FRAC_BITS >= 31) ? 32'sh7fffffff : 32'(64'd1 << FRAC_BITS);

  logic               en;
  logic               issue;
  logic [1:0]         perm;
  logic               refl;
  logic [1:0]         perm_next;
  logic               refl_next;
  logic               run_end;
  logic signed [31:0] sel_p;
  logic signed [31:0] sel_q;
  logic signed [31:0] sel_r;

  logic               va, vb, vc, vd, ve;
  cep_pkg::cep_tag_t  tag_a, tag_b, tag_c, tag_d, tag_e;
  logic signed [31:0] a_p, a_q, a_r, a_d, a_w1;
  logic signed [31:0] b_p, b_q, b_r, b_d, b_w1, b_omr, b_omp, b_omq, b_pmq;
  logic signed [31:0] c_p, c_q, c_r, c_w2, c_s0, c_omp, c_omq, c_pmq;
  logic signed [31:0] d_p, d_q, d_s, d_rs, d_wp, d_t1, d_omp, d_omq, d_pmq;
  logic signed [31:0] e_p, e_q, e_x0, e_x2, e_t1, e_t2, e_wo;
  logic signed [31:0] s_cur;

  assign en      = !(out_valid && out_stall);
  assign issue   = en && !qstat.empty;
  assign run_end = (perm == cep_pkg::PERM_THIRD) && refl;
  assign pop     = issue && run_end;

  always_comb begin
    perm_next = perm;
    refl_next = !refl;
    if (refl) begin
      perm_next = run_end ? cep_pkg::PERM_FIRST : perm + 1'b1;
    end
  end

  always_comb begin
    unique case (perm)
      cep_pkg::PERM_SECOND: begin
        sel_p = head_item.a;
        sel_q = head_item.ca;
        sel_r = head_item.ba;
      end
      cep_pkg::PERM_THIRD: begin
        sel_p = head_item.ba;
        sel_q = head_item.a;
        sel_r = head_item.ca;
      end
      default: begin
        sel_p = head_item.ca;
        sel_q = head_item.ba;
        sel_r = head_item.a;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      perm      <= cep_pkg::PERM_FIRST;
      refl      <= 1'b0;
      va        <= 1'b0;
      vb        <= 1'b0;
      vc        <= 1'b0;
      vd        <= 1'b0;
      ve        <= 1'b0;
      out_valid <= 1'b0;
    end else if (en) begin
      if (issue) begin
        perm <= perm_next;
        refl <= refl_next;
      end
      va        <= issue;
      vb        <= va;
      vc        <= vb;
      vd        <= vc;
      ve        <= vd;
      out_valid <= ve;
    end
  end

  assign s_cur = c_s0;

  always_ff @(posedge clk) begin
    if (en) begin
      // issue
      tag_a.perm    <= perm;
      tag_a.refl    <= refl;
      tag_a.run_end <= run_end;
      tag_a.set_end <= run_end && head_item.last;
      a_p  <= sel_p;
      a_q  <= sel_q;
      a_r  <= sel_r;
      a_d  <= head_item.d;
      a_w1 <= head_item.w1;
      // complements and reflected r
      tag_b <= tag_a;
      b_p   <= a_p;
      b_q   <= a_q;
      b_r   <= tag_a.refl ? cep_pkg::fx_sub('0, a_r) : a_r;
      b_d   <= a_d;
      b_w1  <= a_w1;
      b_omr <= cep_pkg::fx_sub(ONE, a_r);
      b_omp <= cep_pkg::fx_sub(ONE, a_p);
      b_omq <= cep_pkg::fx_sub(ONE, a_q);
      b_pmq <= cep_pkg::fx_sub(a_p, a_q);
      // w2 and s
      tag_c <= tag_b;
      c_p   <= b_p;
      c_q   <= b_q;
      c_r   <= b_r;
      c_w2  <= cep_pkg::fx_mul(b_w1, b_omr, FRAC_BITS);
      c_s0  <= cep_pkg::fx_mul(b_d, b_omr, FRAC_BITS);
      c_omp <= b_omp;
      c_omq <= b_omq;
      c_pmq <= b_pmq;
      // reflected s, first products
      tag_d <= tag_c;
      d_p   <= c_p;
      d_q   <= c_q;
      d_s   <= tag_c.refl ? cep_pkg::fx_sub(ONE, s_cur) : s_cur;
      d_rs  <= cep_pkg::fx_add(c_r,
                 tag_c.refl ? cep_pkg::fx_sub(ONE, s_cur) : s_cur);
      d_wp  <= cep_pkg::fx_mul(c_w2, c_omp, FRAC_BITS);
      d_t1  <= cep_pkg::fx_mul(c_omq, c_r, FRAC_BITS);
      d_omp <= c_omp;
      d_omq <= c_omq;
      d_pmq <= c_pmq;
      // second products
      tag_e <= tag_d;
      e_p   <= d_p;
      e_q   <= d_q;
      e_x0  <= cep_pkg::fx_mul(d_s, d_omp, FRAC_BITS);
      e_x2  <= cep_pkg::fx_mul(d_rs, d_omq, FRAC_BITS);
      e_t1  <= d_t1;
      e_t2  <= cep_pkg::fx_mul(d_s, d_pmq, FRAC_BITS);
      e_wo  <= cep_pkg::fx_mul(d_wp, d_omq, FRAC_BITS);
      // output register
      out_x0      <= e_x0;
      out_x1      <= e_p;
      out_x2      <= e_x2;
      out_x3      <= e_q;
      out_x4      <= cep_pkg::fx_add(e_t1, e_t2);
      weight_out  <= e_wo;
      perm_index  <= tag_e.perm;
      reflected   <= tag_e.refl;
      last_of_run <= tag_e.run_end;
      end_of_set  <= tag_e.set_end;
    end
  end

endmodule

// ----- hw/rtl/common_edge_quad_point_expand.sv -----
// Common-edge Duffy expansion: each input transaction (a, b, c, d, weight) expands into six
// output transactions, the three cyclic permutations of (c*a, b*a, a), each plain and then
// reflected, with all arithmetic in signed fixed point with FRAC_BITS fraction bits, products
// rounded to nearest and every product, sum and difference saturated to 32 bits. The back end
// issues one permutation/reflection per cycle into a six-stage multiplier pipeline, so the
// block sustains one output transaction per cycle while the output is not stalled and the
// queue holds a point; the front end forms the shared products in two stages and parks up to
// four points in a queue, so it keeps taking input while the back end works or the output is
// stalled, until the queue is full.
module common_edge_quad_point_expand #(
  parameter int FRAC_BITS = 30
) (
  input  logic               clk,
  input  logic               rst,
  input  logic               in_valid,
  output logic               in_stall,
  input  logic [30:0]        coord_a,
  input  logic [30:0]        coord_b,
  input  logic [30:0]        coord_c,
  input  logic [30:0]        coord_d,
  input  logic [30:0]        weight_in,
  input  logic               last_point,
  output logic               out_valid,
  input  logic               out_stall,
  output logic signed [31:0] out_x0,
  output logic signed [31:0] out_x1,
  output logic signed [31:0] out_x2,
  output logic signed [31:0] out_x3,
  output logic signed [31:0] out_x4,
  output logic signed [31:0] weight_out,
  output logic [1:0]         perm_index,
  output logic               reflected,
  output logic               last_of_run,
  output logic               end_of_set
);

  cep_pkg::cep_qstat_t qstat;
  cep_pkg::cep_item_t  push_item;
  cep_pkg::cep_item_t  head_item;
  logic                push;
  logic                pop;

  cep_front #(
    .FRAC_BITS(FRAC_BITS)
  ) u_front (
    .clk        (clk),
    .rst        (rst),
    .in_valid   (in_valid),
    .in_stall   (in_stall),
    .coord_a    (coord_a),
    .coord_b    (coord_b),
    .coord_c    (coord_c),
    .coord_d    (coord_d),
    .weight_in  (weight_in),
    .last_point (last_point),
    .qstat      (qstat),
    .push       (push),
    .push_item  (push_item)
  );

  cep_queue u_queue (
    .clk       (clk),
    .rst       (rst),
    .push      (push),
    .push_item (push_item),
    .pop       (pop),
    .head_item (head_item),
    .qstat     (qstat)
  );

  cep_back #(
    .FRAC_BITS(FRAC_BITS)
  ) u_back (
    .clk         (clk),
    .rst         (rst),
    .head_item   (head_item),
    .qstat       (qstat),
    .pop         (pop),
    .out_valid   (out_valid),
    .out_stall   (out_stall),
    .out_x0      (out_x0),
    .out_x1      (out_x1),
    .out_x2      (out_x2),
    .out_x3      (out_x3),
    .out_x4      (out_x4),
    .weight_out  (weight_out),
    .perm_index  (perm_index),
    .reflected   (reflected),
    .last_of_run (last_of_run),
    .end_of_set  (end_of_set)
  );

  assert property (@(posedge clk) disable iff (rst)
    out_valid && last_of_run |-> perm_index == cep_pkg::PERM_THIRD && reflected)
    else $error("run end off the final reflected permutation");

  assert property (@(posedge clk) disable iff (rst)
    out_valid && end_of_set |-> last_of_run)
    else $error("set end without run end");

  assert property (@(posedge clk) disable iff (rst)
    push |-> !qstat.full)
    else $error("queue overflow");

  assert property (@(posedge clk) disable iff (rst)
    pop |-> !qstat.empty)
    else $error("queue underflow");

endmodule
